### hw/rtl/thr_pkg.sv
// shared types and codes for the touch hit test and grab router
// no dependencies; used by thr_cmp and the router by scoped name, and by the bench
package thr_pkg;

  // default table depth
  localparam int NUM_SURFACES_DEF = 16;

  // item kinds on func
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TOUCH = 1'b1;

  // touch phases on touch_kind
  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_UP   = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // event codes on event_type
  localparam logic [1:0] EVT_DOWN = 2'd1;
  localparam logic [1:0] EVT_MOVE = 2'd2;
  localparam logic [1:0] EVT_UP   = 2'd3;

  // one surface table entry as held in the table ram
  typedef struct packed {
    logic [31:0]        recency;
    logic signed [15:0] layer;
    logic [14:0]        height;
    logic [14:0]        width;
    logic signed [15:0] top;
    logic signed [15:0] left;
    logic               deliverable;
    logic               visible;
    logic [15:0]        surf_id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // touch item as seen by the compare unit
  typedef struct packed {
    logic               down;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        grab_id;
  } probe_t;

  // current best candidate as seen by the compare unit
  typedef struct packed {
    logic               have;
    logic signed [15:0] layer;
    logic [31:0]        recency;
  } best_t;

endpackage

### hw/rtl/thr_ram.sv
// generic single write port ram with registered read
// no dependencies
module thr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/thr_cmp.sv
// shared compare unit: hit test of one entry and priority against the best so far
// depends on thr_pkg
module thr_cmp (
  input  thr_pkg::entry_t entry,
  input  logic            entry_valid,
  input  thr_pkg::probe_t probe,
  input  thr_pkg::best_t  best,
  output logic            take
);

  logic signed [16:0] l17;
  logic signed [16:0] t17;
  logic signed [16:0] r17;
  logic signed [16:0] b17;
  logic signed [16:0] x17;
  logic signed [16:0] y17;
  logic               inside_pt;
  logic               better;

  // rectangle edges at 17 bits
  assign l17 = 17'(entry.left);
  assign t17 = 17'(entry.top);
  assign r17 = l17 + $signed({2'b00, entry.width});
  assign b17 = t17 + $signed({2'b00, entry.height});
  assign x17 = 17'(probe.x);
  assign y17 = 17'(probe.y);

  assign inside_pt = (x17 >= l17) && (x17 < r17) && (y17 >= t17) && (y17 < b17);

  // higher layer wins, then higher recency; ties keep the earlier slot
  assign better = (entry.layer > best.layer) ||
                  ((entry.layer == best.layer) && (entry.recency > best.recency));

  // down picks the top hit, move and up take the first id match
  always_comb begin
    if (probe.down) begin
      take = entry_valid && (entry.surf_id != 16'd0) && entry.visible && inside_pt &&
             (!best.have || better);
    end else begin
      take = entry_valid && !best.have && (entry.surf_id == probe.grab_id);
    end
  end

endmodule

### hw/rtl/touch_hit_test_and_grab_router.sv
// touch item that scans: accepted in idle, then the scan state, then fin, which loads the
// result register once it is free, and only then is the next item taken; a write item, a touch of kind three or a move
// or up with no grab skips the scan and goes from idle straight to fin
// the table ram is scanned one slot per cycle through its single read port
// the result sits in an output register, so a new item is taken while it waits
// reset (rst, synchronous) clears all slot valid bits at once and the grab; no clearing pass
module touch_hit_test_and_grab_router #(
  parameter int NUM_SURFACES = thr_pkg::NUM_SURFACES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot[3:0] surf_id[19:4] visible[20] deliverable[21] pos_x[37:22] pos_y[53:38]
  // width[68:54] height[83:69] layer[99:84] recency[131:100], zero pad to 136
  input  logic [135:0] s_axis_tdata,
  // func[0] touch_kind[2:1]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // target_id[15:0] local_x[31:16] local_y[47:32]
  output logic [47:0]  m_axis_tdata,
  // delivered[0] event_type[2:1]
  output logic [2:0]   m_axis_tuser
);

  localparam int AW = (NUM_SURFACES > 1) ? $clog2(NUM_SURFACES) : 1;
  localparam int CW = $clog2(NUM_SURFACES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // input field split
  logic                in_func;
  logic [1:0]          in_kind;
  logic [3:0]          in_slot;
  thr_pkg::entry_t     in_entry;
  logic                in_take;

  assign in_func              = s_axis_tuser[0];
  assign in_kind              = s_axis_tuser[2:1];
  assign in_slot              = s_axis_tdata[3:0];
  assign in_entry.surf_id     = s_axis_tdata[19:4];
  assign in_entry.visible     = s_axis_tdata[20];
  assign in_entry.deliverable = s_axis_tdata[21];
  assign in_entry.left        = s_axis_tdata[37:22];
  assign in_entry.top         = s_axis_tdata[53:38];
  assign in_entry.width       = s_axis_tdata[68:54];
  assign in_entry.height      = s_axis_tdata[83:69];
  assign in_entry.layer       = s_axis_tdata[99:84];
  assign in_entry.recency     = s_axis_tdata[131:100];

  // control state
  logic [1:0]              state;
  logic [CW-1:0]           cnt;
  logic                    eval_v;
  logic                    eval_last;
  logic [NUM_SURFACES-1:0] slot_valid;
  logic                    rd_valid;
  logic [15:0]             grab_id;
  logic                    best_have;

  // item and best-candidate payload
  logic                    quick;
  logic                    it_down;
  logic                    it_up;
  logic signed [15:0]      it_x;
  logic signed [15:0]      it_y;
  thr_pkg::entry_t         best;

  // ram ports
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [AW-1:0]           ram_raddr;
  thr_pkg::entry_t         ram_rdata;
  logic                    issuing;

  // compare unit hookup
  thr_pkg::probe_t         probe;
  thr_pkg::best_t          best_view;
  logic                    take;

  // output side
  logic                    out_free;
  logic                    res_dlv;
  logic [1:0]              res_evt;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // table write on a write item inside the table
  assign ram_we    = in_take && (in_func == thr_pkg::FUNC_WRITE) &&
                     (32'(in_slot) < NUM_SURFACES);
  assign ram_waddr = AW'(in_slot);
  assign issuing   = (state == ST_SCAN) && (cnt < CW'(NUM_SURFACES));
  assign ram_raddr = cnt[AW-1:0];

  thr_ram #(
    .WIDTH(thr_pkg::ENTRY_W),
    .DEPTH(NUM_SURFACES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_entry),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign probe.down        = it_down;
  assign probe.x           = it_x;
  assign probe.y           = it_y;
  assign probe.grab_id     = grab_id;
  assign best_view.have    = best_have;
  assign best_view.layer   = best.layer;
  assign best_view.recency = best.recency;

  thr_cmp u_cmp (
    .entry      (ram_rdata),
    .entry_valid(rd_valid),
    .probe      (probe),
    .best       (best_view),
    .take       (take)
  );

  // result flags from the scan outcome
  assign res_dlv = !quick && best_have && best.deliverable;
  always_comb begin
    if (it_down) begin
      res_evt = thr_pkg::EVT_DOWN;
    end else if (it_up) begin
      res_evt = thr_pkg::EVT_UP;
    end else begin
      res_evt = thr_pkg::EVT_MOVE;
    end
  end

  // sequencer, slot valid bits and grab
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      eval_v     <= 1'b0;
      eval_last  <= 1'b0;
      slot_valid <= '0;
      rd_valid   <= 1'b0;
      grab_id    <= 16'd0;
      best_have  <= 1'b0;
    end else begin
      rd_valid <= slot_valid[ram_raddr];
      if (ram_we) begin
        slot_valid[ram_waddr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            cnt       <= '0;
            eval_v    <= 1'b0;
            best_have <= 1'b0;
            if (in_func == thr_pkg::FUNC_WRITE || in_kind == thr_pkg::KIND_NONE ||
                (in_kind != thr_pkg::KIND_DOWN && grab_id == 16'd0)) begin
              state <= ST_FIN;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            cnt <= cnt + CW'(1);
          end
          eval_v    <= issuing;
          eval_last <= (cnt == CW'(NUM_SURFACES - 1));
          if (eval_v && take) begin
            best_have <= 1'b1;
          end
          if (eval_v && eval_last) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (!quick) begin
              if (!best_have) begin
                if (!it_down) begin
                  grab_id <= 16'd0;
                end
              end else if (!best.deliverable || it_up) begin
                grab_id <= 16'd0;
              end else if (it_down) begin
                grab_id <= best.surf_id;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item capture and best-candidate payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      quick   <= (in_func == thr_pkg::FUNC_WRITE) || (in_kind == thr_pkg::KIND_NONE) ||
                 (in_kind != thr_pkg::KIND_DOWN && grab_id == 16'd0);
      it_down <= (in_kind == thr_pkg::KIND_DOWN);
      it_up   <= (in_kind == thr_pkg::KIND_UP);
      it_x    <= in_entry.left;
      it_y    <= in_entry.top;
    end
    if (state == ST_SCAN && eval_v && take) begin
      best <= ram_rdata;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      if (res_dlv) begin
        m_axis_tdata <= {16'(it_y - best.top), 16'(it_x - best.left), best.surf_id};
        m_axis_tuser <= {res_evt, 1'b1};
      end else begin
        m_axis_tdata <= '0;
        m_axis_tuser <= '0;
      end
    end
  end

endmodule

### test/tb_top.sv
// self-checking bench for the touch hit test and grab router: writes surface slots,
// routes touch gestures and checks every result word against an in-bench predictor
// depends on thr_pkg and touch_hit_test_and_grab_router from the rtl folder

// one input word split into fields
typedef struct packed {
  logic               func;
  logic [3:0]         slot;
  logic [15:0]        surf_id;
  logic               visible;
  logic               deliverable;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [14:0]        width;
  logic [14:0]        height;
  logic signed [15:0] layer;
  logic [31:0]        recency;
  logic [1:0]         kind;
} router_item_t;

// one output word split into fields
typedef struct packed {
  logic        delivered;
  logic [15:0] target_id;
  logic [1:0]  event_type;
  logic [15:0] local_x;
  logic [15:0] local_y;
} route_result_t;

class route_scoreboard;
  thr_pkg::entry_t surf_tab [thr_pkg::NUM_SURFACES_DEF];
  logic [15:0]     grab_id;
  route_result_t   expected_routes [$];
  int              errors;
  int              delivered_cnt;

  function new();
    foreach (surf_tab[i]) surf_tab[i] = '0;
    grab_id = '0;
    errors = 0;
    delivered_cnt = 0;
  endfunction

  function string fmt(route_result_t r);
    return $sformatf("dlv=%0d id=%h evt=%0d x=%h y=%h",
                     r.delivered, r.target_id, r.event_type, r.local_x, r.local_y);
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  // half-open rectangle test, edges at full integer width
  function bit covers(int i, int x, int y);
    int l, t;
    l = $signed(surf_tab[i].left);
    t = $signed(surf_tab[i].top);
    return x >= l && x < l + int'(surf_tab[i].width) &&
           y >= t && y < t + int'(surf_tab[i].height);
  endfunction

  // update the table and grab, queue the route this word should produce
  function void note_item(router_item_t it);
    route_result_t res;
    int hit, x, y;
    bit have;
    res = '0;
    hit = 0;
    have = 1'b0;
    x = $signed(it.pos_x);
    y = $signed(it.pos_y);
    if (it.func == thr_pkg::FUNC_WRITE) begin
      surf_tab[it.slot].surf_id     = it.surf_id;
      surf_tab[it.slot].visible     = it.visible;
      surf_tab[it.slot].deliverable = it.deliverable;
      surf_tab[it.slot].left        = it.pos_x;
      surf_tab[it.slot].top         = it.pos_y;
      surf_tab[it.slot].width       = it.width;
      surf_tab[it.slot].height      = it.height;
      surf_tab[it.slot].layer       = it.layer;
      surf_tab[it.slot].recency     = it.recency;
    end else if (it.kind == thr_pkg::KIND_DOWN) begin
      // topmost layer, then newest stamp, then lowest slot
      for (int i = 0; i < thr_pkg::NUM_SURFACES_DEF; i++) begin
        if (surf_tab[i].surf_id != 0 && surf_tab[i].visible && covers(i, x, y)) begin
          if (!have || $signed(surf_tab[i].layer) > $signed(surf_tab[hit].layer) ||
              (surf_tab[i].layer == surf_tab[hit].layer &&
               surf_tab[i].recency > surf_tab[hit].recency))
            hit = i;
          have = 1'b1;
        end
      end
      if (have) grab_id = surf_tab[hit].surf_id;
    end else if (it.kind != thr_pkg::KIND_NONE && grab_id != 0) begin
      // lowest slot carrying the grabbed id
      for (int i = thr_pkg::NUM_SURFACES_DEF - 1; i >= 0; i--) begin
        if (surf_tab[i].surf_id == grab_id) begin
          hit = i;
          have = 1'b1;
        end
      end
      if (!have) grab_id = '0;
    end
    if (have && !surf_tab[hit].deliverable) begin
      grab_id = '0;
    end else if (have) begin
      res.delivered = 1'b1;
      res.target_id = surf_tab[hit].surf_id;
      case (it.kind)
        thr_pkg::KIND_DOWN: res.event_type = thr_pkg::EVT_DOWN;
        thr_pkg::KIND_MOVE: res.event_type = thr_pkg::EVT_MOVE;
        default:            res.event_type = thr_pkg::EVT_UP;
      endcase
      res.local_x = it.pos_x - surf_tab[hit].left;
      res.local_y = it.pos_y - surf_tab[hit].top;
      if (it.kind == thr_pkg::KIND_UP) grab_id = '0;
      delivered_cnt++;
    end
    expected_routes.push_back(res);
  endfunction

  function void check_event(route_result_t got);
    route_result_t want;
    if (expected_routes.size() == 0) begin
      flag({"unexpected word ", fmt(got)});
      return;
    end
    want = expected_routes.pop_front();
    if (got.delivered !== want.delivered || got.target_id !== want.target_id ||
        got.event_type !== want.event_type || got.local_x !== want.local_x ||
        got.local_y !== want.local_y)
      flag({"expected ", fmt(want), " got ", fmt(got)});
  endfunction

  function void drain_check();
    while (expected_routes.size() != 0)
      flag({"missing word ", fmt(expected_routes.pop_front())});
  endfunction
endclass

module tb_top;
  import thr_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  route_scoreboard board;
  int src_idle = 32;
  int sink_idle = 87;
  int writes = 0;
  int touches = 0;

  touch_hit_test_and_grab_router dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_event(route_result_t'{delivered: m_axis_tuser[0],
                                        target_id: m_axis_tdata[15:0],
                                        event_type: m_axis_tuser[2:1],
                                        local_x: m_axis_tdata[31:16],
                                        local_y: m_axis_tdata[47:32]});
    m_axis_tready <= ($urandom_range(99) >= sink_idle);
  end

  // random fill so fields a word does not use still toggle
  function automatic router_item_t scrambled_item();
    logic [159:0] noise;
    noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return router_item_t'(noise[$bits(router_item_t)-1:0]);
  endfunction

  function automatic router_item_t surface(int slot, int id, int vis, int dlv, int x, int y,
                                           int w, int h, int lay, logic [31:0] stamp);
    router_item_t it;
    it = scrambled_item();
    it.func        = FUNC_WRITE;
    it.slot        = 4'(slot);
    it.surf_id     = 16'(id);
    it.visible     = 1'(vis);
    it.deliverable = 1'(dlv);
    it.pos_x       = 16'(x);
    it.pos_y       = 16'(y);
    it.width       = 15'(w);
    it.height      = 15'(h);
    it.layer       = 16'(lay);
    it.recency     = stamp;
    return it;
  endfunction

  function automatic router_item_t touch_at(logic [1:0] kind, int x, int y);
    router_item_t it;
    it = scrambled_item();
    it.func  = FUNC_TOUCH;
    it.kind  = kind;
    it.pos_x = 16'(x);
    it.pos_y = 16'(y);
    return it;
  endfunction

  // mostly a small crowded area, now and then anywhere
  function automatic int pick_coord();
    if ($urandom_range(9) < 8) return int'($urandom_range(200)) - 100;
    return int'($signed(16'($urandom())));
  endfunction

  function automatic int pick_size();
    int r;
    r = int'($urandom_range(9));
    if (r == 0) return 0;
    if (r < 8) return int'($urandom_range(120));
    return int'($urandom_range(32767));
  endfunction

  function automatic int pick_id();
    int r;
    r = int'($urandom_range(9));
    if (r == 0) return 0;
    if (r < 8) return int'($urandom_range(6, 1));
    return int'($urandom_range(65535));
  endfunction

  function automatic int pick_layer();
    if ($urandom_range(9) < 7) return int'($urandom_range(3)) - 1;
    return int'($signed(16'($urandom())));
  endfunction

  function automatic logic [31:0] pick_stamp();
    if ($urandom_range(9) < 6) return $urandom_range(3);
    return $urandom();
  endfunction

  function automatic router_item_t rand_surface();
    return surface(int'($urandom_range(15)), pick_id(), int'($urandom_range(9) != 0),
                   int'($urandom_range(9) != 0), pick_coord(), pick_coord(),
                   pick_size(), pick_size(), pick_layer(), pick_stamp());
  endfunction

  // offer one word, idling first at random, and wait for the handshake
  task automatic send_item(input router_item_t it);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it.recency, it.layer, it.height, it.width, it.pos_y, it.pos_x,
                      it.deliverable, it.visible, it.surf_id, it.slot};
    s_axis_tuser  <= {it.kind, it.func};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_item(it);
    if (it.func == FUNC_WRITE) writes++;
    else if (it.kind != KIND_NONE) touches++;
  endtask

  // surface writes, a down-move-up gesture, or a stray touch
  task automatic run_gesture();
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 25) begin
      repeat ($urandom_range(3, 1)) send_item(rand_surface());
    end else if (pick < 88) begin
      send_item(touch_at(KIND_DOWN, pick_coord(), pick_coord()));
      repeat ($urandom_range(4)) begin
        if ($urandom_range(9) == 0) send_item(rand_surface());
        send_item(touch_at(KIND_MOVE, pick_coord(), pick_coord()));
      end
      if ($urandom_range(9) != 0) send_item(touch_at(KIND_UP, pick_coord(), pick_coord()));
    end else begin
      send_item(touch_at(2'($urandom_range(3)), pick_coord(), pick_coord()));
    end
  endtask

  initial begin
    int goal;
    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // touches against an empty table
    send_item(touch_at(KIND_MOVE, 0, 0));
    send_item(touch_at(KIND_UP, 0, 0));
    send_item(touch_at(KIND_DOWN, 0, 0));
    send_item(touch_at(KIND_NONE, 5, 5));
    // overlapping pair, plus surfaces at the coordinate extremes
    send_item(surface(0, 1, 1, 1, -10, -10, 20, 20, 0, 5));
    send_item(surface(1, 2, 1, 1, 0, 0, 50, 50, 0, 9));
    send_item(surface(15, 65535, 1, 1, -32768, -32768, 32767, 32767, 32767, 32'hFFFF_FFFF));
    send_item(surface(2, 3, 1, 1, 32767, 32767, 32767, 32767, -32768, 0));
    // newer stamp wins on a layer tie, grab follows outside the rectangle
    send_item(touch_at(KIND_DOWN, 5, 5));
    send_item(touch_at(KIND_MOVE, -200, 300));
    send_item(touch_at(KIND_UP, 60, 60));
    // top layer wins, right edge excluded, 16-bit wrap of local coordinates
    send_item(touch_at(KIND_DOWN, -2, -2));
    send_item(touch_at(KIND_DOWN, -1, -1));
    send_item(touch_at(KIND_DOWN, 32767, 32767));
    send_item(touch_at(KIND_MOVE, -32768, -32768));
    // hit on a surface that cannot take events
    send_item(surface(3, 4, 1, 0, 100, 100, 10, 10, 5, 0));
    send_item(touch_at(KIND_DOWN, 105, 105));
    // zero width and hidden surfaces never hit
    send_item(surface(4, 5, 1, 1, 200, 200, 0, 10, 0, 0));
    send_item(touch_at(KIND_DOWN, 200, 200));
    send_item(surface(5, 6, 0, 1, 300, 300, 10, 10, 0, 0));
    send_item(touch_at(KIND_DOWN, 305, 305));
    // grabbed surface removed under the finger
    send_item(touch_at(KIND_DOWN, 0, -5));
    send_item(surface(0, 0, 1, 1, -10, -10, 20, 20, 0, 5));
    send_item(touch_at(KIND_MOVE, 0, -5));
    // full tie goes to the lower slot
    send_item(surface(6, 7, 1, 1, 1000, 1000, 10, 10, 0, 0));
    send_item(surface(7, 8, 1, 1, 1000, 1000, 10, 10, 0, 0));
    send_item(touch_at(KIND_DOWN, 1005, 1005));

    // random gestures under three idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      src_idle  = (ph == 0) ? 32 : (ph == 1) ? 87 : 0;
      sink_idle = (ph == 0) ? 87 : (ph == 1) ? 32 : 0;
      goal = writes + touches + 150;
      while (writes + touches < goal) run_gesture();
    end
    s_axis_tvalid <= 1'b0;

    // let the last words drain, then watch for strays
    while (board.expected_routes.size() != 0) @(posedge clk);
    repeat (NUM_SURFACES_DEF + 8) @(posedge clk);
    board.drain_check();

    $display("sent %0d surface writes and %0d touches, %0d touches reached a surface",
             writes, touches, board.delivered_cnt);
    $display("%0d failing words", board.errors);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### touch_hit_test_and_grab_router.f
hw/rtl/thr_pkg.sv
hw/rtl/thr_ram.sv
hw/rtl/thr_cmp.sv
hw/rtl/touch_hit_test_and_grab_router.sv
test/tb_top.sv
